// ===== sv/pcgm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcgm_pkg
// Shared types, constants and helper functions for the pixel change and
// gray mask block.
// ----------------------------------------------------------------------------
package pcgm_pkg;

  // Frame geometry and background store layout.
  localparam int unsigned FramePixels = 65536;
  localparam int unsigned AddrW       = (FramePixels > 1) ? $clog2(FramePixels) : 1;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned StoreW      = 3 * ChanW;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgStrictMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStrictThr  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLooseThr   = 2'd2;

  localparam logic [ChanW-1:0] StrictThrReset = 8'd25;
  localparam logic [ChanW-1:0] LooseThrReset  = 8'd10;

  // Sum of squares, division by three through a reciprocal, square root.
  localparam int unsigned SqW        = 2 * ChanW;
  localparam int unsigned SumW       = SqW + 2;
  localparam int unsigned RecipW     = 18;
  localparam int unsigned ProdW      = SumW + RecipW;
  localparam int unsigned RecipShift = 19;
  // ceil(2^19 / 3); exact floor division for every sum below 2^19.
  localparam logic [RecipW-1:0] Recip3 = 18'd174763;
  localparam int unsigned QuotW      = 16;
  localparam int unsigned SqrtSteps  = QuotW / 2;
  localparam int unsigned StepW      = 3;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic             end_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             is_background;
    logic             frame_last;
    logic             frame_has_motion;
  } pix_out_t;

  // Per-pixel fields that ride along the gray pipeline.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             bg;
    logic             eof;
    logic             motion;
  } pass_t;

  // Request from the compare stage into the gray pipeline.
  typedef struct packed {
    logic [SumW-1:0] sq_sum;
    pass_t           pass;
  } gray_req_t;

  typedef struct packed {
    logic [QuotW-1:0] rem;
    logic [QuotW-1:0] root;
  } sqrt_t;

  function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // One step of the digit-by-digit square root; step k works on bit 14 - 2k.
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [StepW-1:0] k);
    sqrt_t            r;
    logic [3:0]       sh;
    logic [QuotW-1:0] bitv;
    logic [QuotW:0]   trial;
    r     = s;
    sh    = 4'd14 - {k, 1'b0};
    bitv  = QuotW'(1) << sh;
    trial = {1'b0, s.root} + {1'b0, bitv};
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[QuotW-1:0];
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.root = s.root >> 1;
    end
    sqrt_step = r;
  endfunction

endpackage

// ===== sv/pcgm_ram.sv =====
// ----------------------------------------------------------------------------
// pcgm_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module pcgm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pcgm_gray.sv =====
// ----------------------------------------------------------------------------
// pcgm_gray
// Gray value pipeline: divide the sum of squares by three, take the integer
// square root in two stages of four steps, and select gray or pass-through.
// ----------------------------------------------------------------------------
module pcgm_gray (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  pcgm_pkg::gray_req_t req_i,
  output logic                req_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcgm_pkg::pix_out_t  out_data_o
);

  // Stage A: sum of squares.
  logic                          a_valid_q;
  logic [pcgm_pkg::SumW-1:0]     a_sum_q;
  pcgm_pkg::pass_t               a_pass_q;
  // Stage B: quotient.
  logic                          b_valid_q;
  logic [pcgm_pkg::QuotW-1:0]    b_quot_q;
  pcgm_pkg::pass_t               b_pass_q;
  // Stage C: square root after the upper four steps.
  logic                          c_valid_q;
  pcgm_pkg::sqrt_t               c_sqrt_q;
  pcgm_pkg::pass_t               c_pass_q;
  // Output register.
  logic                          out_valid_q;
  pcgm_pkg::pix_out_t            out_q;

  logic out_ready, c_ready, b_ready, a_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign c_ready   = !c_valid_q || out_ready;
  assign b_ready   = !b_valid_q || c_ready;
  assign a_ready   = !a_valid_q || b_ready;
  assign req_ready_o = a_ready;

  logic [pcgm_pkg::ProdW-1:0] prod;
  logic [pcgm_pkg::QuotW-1:0] quot;
  pcgm_pkg::sqrt_t            sqrt_hi;
  pcgm_pkg::sqrt_t            sqrt_lo;
  pcgm_pkg::pix_out_t         out_d;

  always_comb begin
    prod = pcgm_pkg::ProdW'(a_sum_q) * pcgm_pkg::ProdW'(pcgm_pkg::Recip3);
    quot = prod[pcgm_pkg::RecipShift +: pcgm_pkg::QuotW];
  end

  always_comb begin
    sqrt_hi.rem  = b_quot_q;
    sqrt_hi.root = '0;
    for (int k = 0; k < pcgm_pkg::SqrtSteps / 2; k++) begin
      sqrt_hi = pcgm_pkg::sqrt_step(sqrt_hi, pcgm_pkg::StepW'(k));
    end
  end

  always_comb begin
    sqrt_lo = c_sqrt_q;
    for (int k = pcgm_pkg::SqrtSteps / 2; k < pcgm_pkg::SqrtSteps; k++) begin
      sqrt_lo = pcgm_pkg::sqrt_step(sqrt_lo, pcgm_pkg::StepW'(k));
    end
  end

  always_comb begin
    if (c_pass_q.bg) begin
      out_d.red_out   = sqrt_lo.root[pcgm_pkg::ChanW-1:0];
      out_d.green_out = sqrt_lo.root[pcgm_pkg::ChanW-1:0];
      out_d.blue_out  = sqrt_lo.root[pcgm_pkg::ChanW-1:0];
    end else begin
      out_d.red_out   = c_pass_q.red;
      out_d.green_out = c_pass_q.green;
      out_d.blue_out  = c_pass_q.blue;
    end
    out_d.is_background    = c_pass_q.bg;
    out_d.frame_last       = c_pass_q.eof;
    out_d.frame_has_motion = c_pass_q.motion;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready)   a_valid_q   <= req_valid_i;
      if (b_ready)   b_valid_q   <= a_valid_q;
      if (c_ready)   c_valid_q   <= b_valid_q;
      if (out_ready) out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && req_valid_i) begin
      a_sum_q  <= req_i.sq_sum;
      a_pass_q <= req_i.pass;
    end
    if (b_ready && a_valid_q) begin
      b_quot_q <= quot;
      b_pass_q <= a_pass_q;
    end
    if (c_ready && b_valid_q) begin
      c_sqrt_q <= sqrt_hi;
      c_pass_q <= b_pass_q;
    end
    if (out_ready && c_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // A background pixel carries the same gray value on all three channels.
  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_background |->
      out_data_o.red_out == out_data_o.green_out &&
      out_data_o.green_out == out_data_o.blue_out)
    else $error("gray result with unequal channels");

  // The motion flag is only reported on the last pixel of a frame.
  a_motion_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_has_motion |-> out_data_o.frame_last)
    else $error("motion flag outside frame end");
`endif

endmodule

// ===== sv/pixel_change_gray_mask.sv =====
// ----------------------------------------------------------------------------
// pixel_change_gray_mask
// Frame difference background subtraction on an RGB pixel stream.
//
//   Channel   Direction  Handshake                    Payload
//   in        input      in_valid_i / in_stall_o      pcgm_pkg::pix_in_t
//   out       output     out_valid_o / out_stall_i    pcgm_pkg::pix_out_t
//   cfg       input      cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// One pixel per clock unless the output stalls. The rate is set by the
// background RAM, which gives one read and one write per cycle. Reset
// clears the control state; the background store needs no clearing pass,
// since the first frame writes every entry it uses. A stall on the output
// backs up through the pipeline, and the input stalls only once the compare
// stage cannot move on.
// ----------------------------------------------------------------------------
module pixel_change_gray_mask (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pcgm_pkg::pix_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pcgm_pkg::pix_out_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pcgm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pcgm_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // Configuration registers.
  logic                         strict_mode_q;
  logic [pcgm_pkg::ChanW-1:0]   strict_thr_q;
  logic [pcgm_pkg::ChanW-1:0]   loose_thr_q;

  // Frame state.
  logic [pcgm_pkg::AddrW-1:0]   addr_q, addr_d;
  logic                         first_frame_q;
  logic                         motion_seen_q;

  // Compare stage.
  logic                         s1_valid_q;
  pcgm_pkg::pix_in_t            s1_q;
  logic [pcgm_pkg::AddrW-1:0]   s1_addr_q;
  logic                         fwd_hit_q;
  logic [pcgm_pkg::StoreW-1:0]  fwd_data_q;

  logic                         gray_ready;
  logic                         accept_in;
  logic                         s1_advance;

  assign in_stall_o = s1_valid_q && !gray_ready;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign s1_advance = s1_valid_q && gray_ready;

  always_comb begin
    if (in_data_i.end_of_frame ||
        addr_q == pcgm_pkg::AddrW'(pcgm_pkg::FramePixels - 1)) begin
      addr_d = '0;
    end else begin
      addr_d = addr_q + 1'b1;
    end
  end

  // Background store access.
  logic                         wr_en;
  logic [pcgm_pkg::StoreW-1:0]  wr_data;
  logic [pcgm_pkg::StoreW-1:0]  rd_data;

  pcgm_ram #(
    .Width (pcgm_pkg::StoreW),
    .Depth (pcgm_pkg::FramePixels)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (accept_in),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // Compare against the stored background.
  logic [pcgm_pkg::StoreW-1:0]  stored;
  logic [pcgm_pkg::ChanW-1:0]   dr, dg, db;
  logic                         bg;
  logic                         motion_next;
  logic [pcgm_pkg::SqW-1:0]     sq_r, sq_g, sq_b;
  pcgm_pkg::gray_req_t          gray_req;

  always_comb begin
    wr_data = {s1_q.red_in, s1_q.green_in, s1_q.blue_in};
    // The first frame loads the store; an entry written in the cycle of its
    // read comes from the forwarding register instead of the RAM.
    if (first_frame_q) begin
      stored = wr_data;
    end else if (fwd_hit_q) begin
      stored = fwd_data_q;
    end else begin
      stored = rd_data;
    end
    dr = pcgm_pkg::abs_diff(s1_q.red_in,   stored[2*pcgm_pkg::ChanW +: pcgm_pkg::ChanW]);
    dg = pcgm_pkg::abs_diff(s1_q.green_in, stored[pcgm_pkg::ChanW +: pcgm_pkg::ChanW]);
    db = pcgm_pkg::abs_diff(s1_q.blue_in,  stored[0 +: pcgm_pkg::ChanW]);
    if (strict_mode_q) begin
      bg = (dr < strict_thr_q) && (dg < strict_thr_q) && (db < strict_thr_q);
    end else begin
      bg = (dr <= loose_thr_q) || (dg <= loose_thr_q) || (db <= loose_thr_q);
    end
    motion_next = motion_seen_q || !bg;
    wr_en       = s1_advance && (first_frame_q || !bg);

    sq_r = pcgm_pkg::SqW'(s1_q.red_in)   * pcgm_pkg::SqW'(s1_q.red_in);
    sq_g = pcgm_pkg::SqW'(s1_q.green_in) * pcgm_pkg::SqW'(s1_q.green_in);
    sq_b = pcgm_pkg::SqW'(s1_q.blue_in)  * pcgm_pkg::SqW'(s1_q.blue_in);

    gray_req.sq_sum      = pcgm_pkg::SumW'(sq_r) + pcgm_pkg::SumW'(sq_g) +
                           pcgm_pkg::SumW'(sq_b);
    gray_req.pass.red    = s1_q.red_in;
    gray_req.pass.green  = s1_q.green_in;
    gray_req.pass.blue   = s1_q.blue_in;
    gray_req.pass.bg     = bg;
    gray_req.pass.eof    = s1_q.end_of_frame;
    gray_req.pass.motion = s1_q.end_of_frame && motion_next;
  end

  pcgm_gray u_gray (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s1_valid_q),
    .req_i       (gray_req),
    .req_ready_o (gray_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_mode_q <= 1'b0;
      strict_thr_q  <= pcgm_pkg::StrictThrReset;
      loose_thr_q   <= pcgm_pkg::LooseThrReset;
      addr_q        <= '0;
      first_frame_q <= 1'b1;
      motion_seen_q <= 1'b0;
      s1_valid_q    <= 1'b0;
      fwd_hit_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pcgm_pkg::CfgStrictMode: strict_mode_q <= cfg_wdata_i[0];
          pcgm_pkg::CfgStrictThr:  strict_thr_q  <= cfg_wdata_i[pcgm_pkg::ChanW-1:0];
          pcgm_pkg::CfgLooseThr:   loose_thr_q   <= cfg_wdata_i[pcgm_pkg::ChanW-1:0];
          default: ;
        endcase
      end
      if (accept_in) begin
        addr_q    <= addr_d;
        fwd_hit_q <= wr_en && (s1_addr_q == addr_q);
      end
      if (!s1_valid_q || gray_ready) begin
        s1_valid_q <= accept_in;
      end
      if (s1_advance) begin
        if (s1_q.end_of_frame) begin
          motion_seen_q <= 1'b0;
          first_frame_q <= 1'b0;
        end else begin
          motion_seen_q <= motion_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_q       <= in_data_i;
      s1_addr_q  <= addr_q;
      fwd_data_q <= wr_data;
    end
  end

`ifndef ASSERT_OFF
  // Every pixel of the first frame is written into the store.
  a_first_frame_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && first_frame_q |-> wr_en)
    else $error("first frame pixel not stored");

  // A frame end restarts the address count.
  a_addr_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in && in_data_i.end_of_frame |=> addr_q == '0)
    else $error("address did not restart after frame end");

  // Leaving a frame end clears the motion and first-frame state.
  a_frame_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && s1_q.end_of_frame |=> !motion_seen_q && !first_frame_q)
    else $error("frame state not cleared at frame end");
`endif

endmodule

// ===== sim/pcgm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcgm_checker
// Watches the pixel and result channels of the gray mask block, keeps its own
// background store and frame state, predicts every result and compares the
// results field by field in the order they arrive.
// ----------------------------------------------------------------------------
module pcgm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  pcgm_pkg::pix_in_t               in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  pcgm_pkg::pix_out_t              out_data_i,
  input  logic                            cfg_we_i,
  input  logic [pcgm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pcgm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output int                              pending_o,
  output int                              errors_o
);

  logic [pcgm_pkg::StoreW-1:0] bg_store [pcgm_pkg::FramePixels];
  logic [pcgm_pkg::AddrW-1:0]  pix_addr;
  logic                        first_frame;
  logic                        motion_seen;
  logic                        strict_mode;
  logic [pcgm_pkg::ChanW-1:0]  strict_thr;
  logic [pcgm_pkg::ChanW-1:0]  loose_thr;
  pcgm_pkg::pix_out_t          expected_px [$];

  function automatic logic [pcgm_pkg::ChanW-1:0] chan_gap(logic [pcgm_pkg::ChanW-1:0] a,
                                                          logic [pcgm_pkg::ChanW-1:0] b);
    chan_gap = (a > b) ? a - b : b - a;
  endfunction

  // Luma-like gray level: integer square root of the mean of squares.
  function automatic logic [pcgm_pkg::ChanW-1:0] gray_level(pcgm_pkg::pix_in_t px);
    logic [17:0]                sum;
    logic [15:0]                quot;
    logic [pcgm_pkg::ChanW-1:0] root;
    logic [pcgm_pkg::ChanW-1:0] trial;
    sum  = 18'(px.red_in) * px.red_in + 18'(px.green_in) * px.green_in
         + 18'(px.blue_in) * px.blue_in;
    quot = 16'(sum / 3);
    root = '0;
    for (int b = pcgm_pkg::ChanW - 1; b >= 0; b--) begin
      trial = root | pcgm_pkg::ChanW'(1 << b);
      if (16'(trial) * trial <= quot) root = trial;
    end
    gray_level = root;
  endfunction

  task automatic take_pixel(input pcgm_pkg::pix_in_t px);
    logic [pcgm_pkg::StoreW-1:0] now_rgb;
    logic [pcgm_pkg::StoreW-1:0] ref_rgb;
    logic [pcgm_pkg::ChanW-1:0]  dr;
    logic [pcgm_pkg::ChanW-1:0]  dg;
    logic [pcgm_pkg::ChanW-1:0]  db;
    logic [pcgm_pkg::ChanW-1:0]  gl;
    logic                        bg;
    pcgm_pkg::pix_out_t          res;
    now_rgb = {px.red_in, px.green_in, px.blue_in};
    if (first_frame) bg_store[pix_addr] = now_rgb;
    ref_rgb = bg_store[pix_addr];
    dr = chan_gap(px.red_in, ref_rgb[23:16]);
    dg = chan_gap(px.green_in, ref_rgb[15:8]);
    db = chan_gap(px.blue_in, ref_rgb[7:0]);
    if (strict_mode) begin
      bg = (dr < strict_thr) && (dg < strict_thr) && (db < strict_thr);
    end else begin
      bg = (dr <= loose_thr) || (dg <= loose_thr) || (db <= loose_thr);
    end
    if (bg) begin
      gl = gray_level(px);
      res.red_out   = gl;
      res.green_out = gl;
      res.blue_out  = gl;
    end else begin
      bg_store[pix_addr] = now_rgb;
      motion_seen   = 1'b1;
      res.red_out   = px.red_in;
      res.green_out = px.green_in;
      res.blue_out  = px.blue_in;
    end
    res.is_background    = bg;
    res.frame_last       = px.end_of_frame;
    res.frame_has_motion = px.end_of_frame & motion_seen;
    if (px.end_of_frame) begin
      pix_addr    = '0;
      motion_seen = 1'b0;
      first_frame = 1'b0;
    end else begin
      // A frame that runs past the store size wraps and keeps going.
      pix_addr = (pix_addr == pcgm_pkg::AddrW'(pcgm_pkg::FramePixels - 1)) ?
                 '0 : pix_addr + 1'b1;
    end
    expected_px.insert(expected_px.size(), res);
  endtask

  task automatic check_field(input string label, input logic [pcgm_pkg::ChanW-1:0] want,
                             input logic [pcgm_pkg::ChanW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
      errors_o++;
    end
  endtask

  task automatic check_result(input pcgm_pkg::pix_out_t got);
    pcgm_pkg::pix_out_t want;
    if (expected_px.size() == 0) begin
      $display("%0t: result %h arrived with no request outstanding", $time, got);
      errors_o++;
    end else begin
      want = expected_px.pop_front();
      check_field("red_out", want.red_out, got.red_out);
      check_field("green_out", want.green_out, got.green_out);
      check_field("blue_out", want.blue_out, got.blue_out);
      check_field("is_background", want.is_background, got.is_background);
      check_field("frame_last", want.frame_last, got.frame_last);
      check_field("frame_has_motion", want.frame_has_motion, got.frame_has_motion);
    end
  endtask

  // Results are retired before the request of the same edge is predicted;
  // register writes only affect later requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_addr    = '0;
      first_frame = 1'b1;
      motion_seen = 1'b0;
      strict_mode = 1'b0;
      strict_thr  = pcgm_pkg::StrictThrReset;
      loose_thr   = pcgm_pkg::LooseThrReset;
      expected_px.delete();
      pending_o   = 0;
      errors_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) take_pixel(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pcgm_pkg::CfgStrictMode: strict_mode = cfg_wdata_i[0];
          pcgm_pkg::CfgStrictThr:  strict_thr  = cfg_wdata_i[pcgm_pkg::ChanW-1:0];
          pcgm_pkg::CfgLooseThr:   loose_thr   = cfg_wdata_i[pcgm_pkg::ChanW-1:0];
          default: ;
        endcase
      end
      pending_o = expected_px.size();
    end
  end

endmodule

// ===== sim/tb_pixel_change_gray_mask.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_change_gray_mask
// Drives RGB pixel frames and register settings into the gray mask block
// with random gaps and output stalls. A first frame as long as the longest
// later frame loads every entry that is read afterwards, a short directed
// part probes the thresholds, and random phases follow; the checker beside
// the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_pixel_change_gray_mask;

  localparam int unsigned SceneN     = 64;
  localparam int unsigned IdlePct    = 38;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned Phases     = 13;
  localparam int unsigned FirstLen   = 200;
  localparam int unsigned LongMin    = 100;
  localparam logic [pcgm_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  pcgm_pkg::pix_in_t               in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  pcgm_pkg::pix_out_t              out_data;
  logic                            cfg_we    = 1'b0;
  logic [pcgm_pkg::CfgIdxW-1:0]    cfg_idx   = pcgm_pkg::CfgStrictMode;
  logic [pcgm_pkg::CfgDataW-1:0]   cfg_wdata = '0;
  int                              pending;
  int                              errors;
  logic                            calm      = 1'b0;
  logic [pcgm_pkg::ChanW-1:0]      cur_st    = pcgm_pkg::StrictThrReset;
  logic [pcgm_pkg::ChanW-1:0]      cur_lt    = pcgm_pkg::LooseThrReset;
  logic [23:0]                     scene [SceneN];
  int unsigned                     quiet_cycles = 0;

  always #10 clk = ~clk;

  pixel_change_gray_mask dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  pcgm_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_pixel_change_gray_mask: errors");
      $finish;
    end
  end

  // Moves each channel toward mid-range so that the offset never wraps.
  function automatic logic [23:0] nudge_px(logic [23:0] p, int unsigned dr,
                                           int unsigned dg, int unsigned db);
    logic [23:0] q;
    logic [7:0]  v;
    logic [7:0]  d [3];
    d[0] = 8'(dr);
    d[1] = 8'(dg);
    d[2] = 8'(db);
    for (int c = 0; c < 3; c++) begin
      v = p[23 - 8 * c -: 8];
      q[23 - 8 * c -: 8] = (v < 8'd128) ? v + d[c] : v - d[c];
    end
    nudge_px = q;
  endfunction

  // A pixel close to the last one at its position, with offsets that
  // straddle the current thresholds.
  function automatic logic [23:0] near_pixel(logic [23:0] p);
    logic [23:0] q;
    int          span;
    int          v;
    int          d;
    span = ((cur_st > cur_lt) ? int'(cur_st) : int'(cur_lt)) + 8;
    if (span > 255) span = 255;
    for (int c = 0; c < 3; c++) begin
      d = $urandom_range(span);
      v = int'(p[8 * c +: 8]);
      if ($urandom_range(1) == 1 && v + d <= 255) v = v + d;
      else if (v >= d) v = v - d;
      else v = (v + d > 255) ? int'($urandom_range(255)) : v + d;
      q[8 * c +: 8] = v[7:0];
    end
    near_pixel = q;
  endfunction

  task automatic send_pixel(input logic [23:0] rgb, input logic eof);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.red_in       = rgb[23:16];
    in_data.green_in     = rgb[15:8];
    in_data.blue_in      = rgb[7:0];
    in_data.end_of_frame = eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_set(input logic [23:0] row [4], input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      scene[i] = row[i];
      send_pixel(row[i], i == n - 1);
    end
  endtask

  task automatic send_frame(input int unsigned len);
    logic [23:0] rgb;
    for (int unsigned i = 0; i < len; i++) begin
      if (i < SceneN && $urandom_range(99) < 80) rgb = near_pixel(scene[i]);
      else rgb = 24'($urandom);
      if (i < SceneN) scene[i] = rgb;
      send_pixel(rgb, i == len - 1);
    end
  endtask

  // Registers change only while no request is in flight.
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pcgm_pkg::CfgIdxW-1:0] idx,
                           input logic [pcgm_pkg::CfgDataW-1:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_mode(input logic strict, input logic [7:0] st, input logic [7:0] lt);
    settle();
    // Upper bits of the mode register must be ignored.
    write_reg(pcgm_pkg::CfgStrictMode, {7'($urandom), strict});
    write_reg(pcgm_pkg::CfgStrictThr, st);
    write_reg(pcgm_pkg::CfgLooseThr, lt);
    write_reg(CfgUnused, 8'($urandom));
    cur_st = st;
    cur_lt = lt;
  endtask

  initial begin
    logic [23:0] base [4];
    logic [23:0] row [4];
    logic [23:0] rgb;
    int unsigned sent;
    int unsigned len;
    int unsigned pick;

    base[0] = 24'h000000;
    base[1] = 24'hFFFFFF;
    base[2] = 24'hFF00FF;
    base[3] = 24'h807F01;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The first frame is as long as the longest later frame, so every store
    // entry that a later frame reads has been written.
    calm = 1'b1;
    for (int unsigned n = 0; n < FirstLen; n++) begin
      rgb = 24'($urandom);
      if (n < SceneN) scene[n] = rgb;
      send_pixel(rgb, n == FirstLen - 1);
    end
    calm = 1'b0;

    // With a zero strict threshold nothing matches, so the store takes the
    // base pixels exactly.
    set_mode(1'b1, 8'd0, 8'd10);
    send_set(base, 4);
    set_mode(1'b1, 8'd25, 8'd10);
    row[0] = nudge_px(base[0], 24, 24, 24);
    row[1] = nudge_px(base[1], 25, 24, 24);
    row[2] = nudge_px(base[2], 24, 25, 24);
    row[3] = nudge_px(base[3], 24, 24, 25);
    send_set(row, 4);
    set_mode(1'b1, 8'd0, 8'd10);
    send_set(base, 4);
    set_mode(1'b0, 8'd25, 8'd10);
    row[0] = nudge_px(base[0], 11, 11, 11);
    row[1] = nudge_px(base[1], 10, 11, 11);
    row[2] = nudge_px(base[2], 11, 10, 11);
    row[3] = nudge_px(base[3], 11, 11, 10);
    send_set(row, 4);
    // Everything matches at the top loose threshold: gray extremes.
    set_mode(1'b0, 8'd25, 8'd255);
    row[0] = 24'h000000;
    row[1] = 24'hFFFFFF;
    send_set(row, 2);

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: set_mode(1'b0, 8'd25, 8'd10);
        1: set_mode(1'b1, 8'd25, 8'd10);
        2: set_mode(1'b1, 8'd0, 8'd10);
        3: set_mode(1'b1, 8'd255, 8'd0);
        4: set_mode(1'b0, 8'd25, 8'd0);
        5: set_mode(1'b0, 8'd1, 8'd255);
        6: set_mode(1'b1, 8'd1, 8'd1);
        default: set_mode(1'($urandom_range(1)), 8'($urandom_range(60)),
                          8'($urandom_range(40)));
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 5) len = $urandom_range(FirstLen, LongMin);
        else if (pick < 15) len = $urandom_range(3, 1);
        else len = $urandom_range(48, 1);
        send_frame(len);
        sent += len;
      end
    end

    settle();
    if (errors == 0) begin
      $display("tb_pixel_change_gray_mask: clean");
    end else begin
      $display("tb_pixel_change_gray_mask: errors");
    end
    $finish;
  end

endmodule
